>>> design/pbpfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpfm_pkg
// Shared types and constants for the page buffer pool frame manager.
// ----------------------------------------------------------------------------
package pbpfm_pkg;

  localparam int unsigned PoolSize = 16;
  localparam int unsigned PinBits  = 8;
  localparam int unsigned FrameW   = $clog2(PoolSize);
  localparam int unsigned CountW   = $clog2(PoolSize + 1);
  localparam logic [PinBits-1:0] PinMax = '1;
  localparam logic [31:0] NoPage  = 32'hFFFF_FFFF;
  localparam logic [31:0] IdLimit = 32'h8000_0000;

  localparam logic [2:0] ReqNew      = 3'd0;
  localparam logic [2:0] ReqFetch    = 3'd1;
  localparam logic [2:0] ReqUnpin    = 3'd2;
  localparam logic [2:0] ReqDelete   = 3'd3;
  localparam logic [2:0] ReqFlushOne = 3'd4;
  localparam logic [2:0] ReqFlushAll = 3'd5;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StNotFound   = 3'd1;
  localparam logic [2:0] StNoFrame    = 3'd2;
  localparam logic [2:0] StPinned     = 3'd3;
  localparam logic [2:0] StNotPinned  = 3'd4;
  localparam logic [2:0] StInvalid    = 3'd5;
  localparam logic [2:0] StOverflow   = 3'd6;

  localparam logic CfgInstCount = 1'b0;
  localparam logic CfgInstNum   = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] page_id;
    logic               mark_dirty;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         frame_index;
    logic signed [31:0] page_out;
    logic               writeback_valid;
    logic signed [31:0] writeback_page;
    logic               read_valid;
    logic               last;
  } rsp_t;

endpackage

>>> design/page_buffer_pool_frame_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_buffer_pool_frame_manager_unit
// Frame manager for a page buffer pool with FIFO free list and LRU victims.
//
// Request channel (req_*) carries one request per transfer; the response
// channel (rsp_*) returns one result per request, or for flush all one result
// per dirty frame followed by a closing result with last set.
// Frame state (page, pins, dirty) lives in a synchronous memory with a
// registered read port. Every request but flush all walks all frames, one
// read per cycle, to find the page; new or a fetch miss that takes a frame
// needs a second read, of the victim entry.
// Flush all reads and checks the frames one at a time; the closing result
// follows the last frame and any write-back results for dirty frames.
// Free list and LRU list are small register queues updated in one step.
// The block takes one request at a time; req_stall_o is high while busy.
// Results sit in an output register; while rsp_stall_i is high the result
// holds and the flush walk pauses.
// Reset empties all frames, fills the free list with frames 0..15 in order,
// empties the LRU list and loads next page id from instance_number (0).
// Configuration writes go straight to the registers; writing
// instance_number also reloads the next page id.
// ----------------------------------------------------------------------------
module page_buffer_pool_frame_manager_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  pbpfm_pkg::req_t     req_data_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output pbpfm_pkg::rsp_t     rsp_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import pbpfm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_VREAD, S_EXEC, S_FLUSH, S_OUT} state_e;

  localparam int unsigned EntW = 32 + PinBits + 1;

  state_e              state_q;
  logic [7:0]          icount_q;
  logic [31:0]         next_q;
  req_t                req_q;
  rsp_t                rsp_q;
  logic                rsp_v_q;

  logic [EntW-1:0]     mem [PoolSize];
  logic [EntW-1:0]     rd_q;
  logic [FrameW-1:0]   raddr_q, rfr_q;
  logic                rdv_q, raddr_done_q;
  logic                mem_we;
  logic [FrameW-1:0]   mem_wa;
  logic [EntW-1:0]     mem_wd;

  logic [PoolSize-1:0] init_q;
  logic [FrameW-1:0]   freeq_q [PoolSize];
  logic [CountW-1:0]   fcnt_q;
  logic [FrameW-1:0]   lru_q [PoolSize];
  logic [CountW-1:0]   lcnt_q;

  logic                hit_q;
  logic [FrameW-1:0]   hfr_q;
  logic [31:0]         hpg_q;
  logic [PinBits-1:0]  hpin_q;
  logic                hdirty_q;
  // victim entry (read for new/fetch miss)
  logic                vic_q;

  logic [31:0]         rpage;
  logic [PinBits-1:0]  rpins;
  logic                rdirty;
  logic                accept, rsp_go;

  assign rpage  = init_q[rfr_q] ? rd_q[EntW-1 -: 32] : NoPage;
  assign rpins  = init_q[rfr_q] ? rd_q[PinBits:1] : '0;
  assign rdirty = init_q[rfr_q] ? rd_q[0] : 1'b0;

  assign req_stall_o = (state_q != S_IDLE);
  assign accept      = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_data_o  = rsp_q;
  assign rsp_go      = rsp_v_q && !rsp_stall_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[raddr_q];
  end

  function automatic rsp_t mk(logic [2:0] st, logic [FrameW-1:0] fr, logic [31:0] pg,
                              logic wbv, logic [31:0] wbp, logic rdv, logic lst);
    rsp_t r;
    r.status          = st;
    r.frame_index     = 4'(fr);
    r.page_out        = pg;
    r.writeback_valid = wbv;
    r.writeback_page  = wbv ? wbp : NoPage;
    r.read_valid      = rdv;
    r.last            = lst;
    return r;
  endfunction

  logic [32:0] nx_sum;
  assign nx_sum = {1'b0, next_q} + 33'(icount_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      icount_q     <= 8'd1;
      next_q       <= '0;
      rsp_v_q      <= 1'b0;
      rdv_q        <= 1'b0;
      raddr_done_q <= 1'b0;
      raddr_q      <= '0;
      rfr_q        <= '0;
      init_q       <= '0;
      fcnt_q       <= CountW'(PoolSize);
      lcnt_q       <= '0;
      hit_q        <= 1'b0;
      vic_q        <= 1'b0;
      for (int i = 0; i < PoolSize; i++) begin
        freeq_q[i] <= FrameW'(i);
        lru_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgInstCount) icount_q <= cfg_data_i;
        else next_q <= 32'(cfg_data_i);
      end
      if (mem_we) init_q[mem_wa] <= 1'b1;
      // rd_q always holds the entry at rfr_q
      rfr_q <= raddr_q;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q        <= req_data_i;
            raddr_q      <= '0;
            rdv_q        <= 1'b0;
            raddr_done_q <= 1'b0;
            hit_q        <= 1'b0;
            vic_q        <= 1'b0;
            state_q      <= (req_data_i.req_type == ReqFlushAll) ? S_FLUSH : S_SCAN;
          end
        end
        S_SCAN: begin
          // stream reads, compare one per cycle
          rdv_q <= !raddr_done_q;
          if (!raddr_done_q) begin
            if (raddr_q == FrameW'(PoolSize - 1)) raddr_done_q <= 1'b1;
            else raddr_q <= raddr_q + 1'b1;
          end
          if (rdv_q && !hit_q && rpage == req_q.page_id) begin
            hit_q    <= 1'b1;
            hfr_q    <= rfr_q;
            hpg_q    <= rpage;
            hpin_q   <= rpins;
            hdirty_q <= rdirty;
          end
          if (raddr_done_q && rdv_q) state_q <= S_EXEC;
        end
        S_VREAD: begin
          rdv_q <= 1'b1;
          if (rdv_q) begin
            // victim read landed
            hfr_q    <= rfr_q;
            hpg_q    <= rpage;
            hdirty_q <= rdirty;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          exec_step();
        end
        S_FLUSH: begin
          if (rsp_go) begin
            rsp_v_q <= 1'b0;
          end else if (!rsp_v_q) begin
            if (raddr_done_q) begin
              rsp_q   <= mk(StOk, '0, NoPage, 1'b0, '0, 1'b0, 1'b1);
              rsp_v_q <= 1'b1;
              state_q <= S_OUT;
            end else if (rdv_q) begin
              if (rdirty && rpage != NoPage) begin
                rsp_q   <= mk(StOk, rfr_q, rpage, 1'b1, rpage, 1'b0, 1'b0);
                rsp_v_q <= 1'b1;
              end
              rdv_q <= 1'b0;
              if (raddr_q == FrameW'(PoolSize - 1)) raddr_done_q <= 1'b1;
              else raddr_q <= raddr_q + 1'b1;
            end else begin
              rdv_q <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (rsp_go) begin
            rsp_v_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Decision step; also arms the victim read for a frame allocation.
  task automatic exec_step();
    logic [2:0]  rt;
    logic [31:0] pg;
    logic        take;
    rt   = req_q.req_type;
    pg   = req_q.page_id;
    take = 1'b0;
    if (rt > ReqFlushAll) begin
      rsp_q <= mk(StInvalid, '0, pg, 1'b0, '0, 1'b0, 1'b1);
    end else if (rt != ReqNew && pg[31]) begin
      rsp_q <= mk(StInvalid, '0, pg, 1'b0, '0, 1'b0, 1'b1);
    end else if (vic_q) begin
      // victim loaded in hfr/hpg/hdirty; install the page
      rsp_q <= mk(StOk, hfr_q, (rt == ReqNew) ? next_q : pg,
                  hdirty_q && hpg_q != NoPage, hpg_q, rt == ReqFetch, 1'b1);
      if (rt == ReqNew) next_q <= nx_sum > {1'b0, IdLimit} ? IdLimit : nx_sum[31:0];
    end else if (rt == ReqFetch && hit_q) begin
      if (hpin_q == PinMax) rsp_q <= mk(StOverflow, hfr_q, pg, 1'b0, '0, 1'b0, 1'b1);
      else begin
        if (hpin_q == '0) lru_del(hfr_q);
        rsp_q <= mk(StOk, hfr_q, pg, 1'b0, '0, 1'b0, 1'b1);
      end
    end else if (rt == ReqNew || rt == ReqFetch) begin
      if (rt == ReqNew && next_q >= IdLimit) begin
        rsp_q <= mk(StOverflow, '0, NoPage, 1'b0, '0, 1'b0, 1'b1);
      end else if (fcnt_q == '0 && lcnt_q == '0) begin
        rsp_q <= mk(StNoFrame, '0, (rt == ReqNew) ? NoPage : pg, 1'b0, '0, 1'b0, 1'b1);
      end else begin
        if (fcnt_q != '0) begin
          raddr_q <= freeq_q[0];
          for (int i = 0; i < PoolSize - 1; i++) freeq_q[i] <= freeq_q[i + 1];
          fcnt_q <= fcnt_q - 1'b1;
        end else begin
          raddr_q <= lru_q[0];
          for (int i = 0; i < PoolSize - 1; i++) lru_q[i] <= lru_q[i + 1];
          lcnt_q <= lcnt_q - 1'b1;
        end
        vic_q <= 1'b1;
        rdv_q <= 1'b0;
        take  = 1'b1;
      end
    end else if (!hit_q) begin
      rsp_q <= mk((rt == ReqDelete) ? StOk : StNotFound, '0, pg, 1'b0, '0, 1'b0, 1'b1);
    end else if (rt == ReqUnpin) begin
      if (hpin_q == '0) rsp_q <= mk(StNotPinned, hfr_q, pg, 1'b0, '0, 1'b0, 1'b1);
      else begin
        if (hpin_q == PinBits'(1) && lcnt_q < CountW'(PoolSize)) begin
          lru_q[lcnt_q[FrameW-1:0]] <= hfr_q;
          lcnt_q <= lcnt_q + 1'b1;
        end
        rsp_q <= mk(StOk, hfr_q, pg, 1'b0, '0, 1'b0, 1'b1);
      end
    end else if (rt == ReqDelete) begin
      if (hpin_q != '0) rsp_q <= mk(StPinned, hfr_q, pg, 1'b0, '0, 1'b0, 1'b1);
      else begin
        lru_del(hfr_q);
        if (fcnt_q < CountW'(PoolSize)) begin
          freeq_q[fcnt_q[FrameW-1:0]] <= hfr_q;
          fcnt_q <= fcnt_q + 1'b1;
        end
        rsp_q <= mk(StOk, hfr_q, pg, hdirty_q, pg, 1'b0, 1'b1);
      end
    end else begin
      rsp_q <= mk(StOk, hfr_q, pg, 1'b1, pg, 1'b0, 1'b1);
    end
    if (take) begin
      state_q <= S_VREAD;
    end else begin
      state_q <= S_OUT;
      rsp_v_q <= 1'b1;
    end
  endtask

  task automatic lru_del(logic [FrameW-1:0] fr);
    logic              found;
    found = 1'b0;
    for (int i = 0; i < PoolSize - 1; i++) begin
      if (CountW'(i) < lcnt_q && lru_q[i] == fr) found = 1'b1;
      if (found) lru_q[i] <= lru_q[i + 1];
    end
    if (!found && lcnt_q == CountW'(PoolSize) && lru_q[PoolSize - 1] == fr) found = 1'b1;
    if (found) lcnt_q <= lcnt_q - 1'b1;
  endtask

  // Memory write-back of the modified entry.
  always_comb begin
    logic [2:0] rt;
    rt     = req_q.req_type;
    mem_we = 1'b0;
    mem_wa = hfr_q;
    mem_wd = {hpg_q, hpin_q, hdirty_q};
    if (state_q == S_FLUSH && !rsp_v_q && !raddr_done_q && rdv_q
        && rdirty && rpage != NoPage) begin
      mem_we = 1'b1;
      mem_wa = rfr_q;
      mem_wd = {rpage, rpins, 1'b0};
    end else if (state_q == S_EXEC && rt <= ReqFlushOne
                 && !(rt != ReqNew && req_q.page_id[31])) begin
      if (vic_q) begin
        mem_we = 1'b1;
        mem_wd = {((rt == ReqNew) ? next_q : 32'(req_q.page_id)), PinBits'(1), 1'b0};
      end else if (hit_q) begin
        case (rt)
          ReqFetch: if (hpin_q != PinMax) begin
            mem_we = 1'b1;
            mem_wd = {hpg_q, hpin_q + 1'b1, hdirty_q};
          end
          ReqUnpin: if (hpin_q != '0) begin
            mem_we = 1'b1;
            mem_wd = {hpg_q, hpin_q - 1'b1, hdirty_q | req_q.mark_dirty};
          end
          ReqDelete: if (hpin_q == '0) begin
            mem_we = 1'b1;
            mem_wd = {NoPage, PinBits'(0), 1'b0};
          end
          ReqFlushOne: begin
            mem_we = 1'b1;
            mem_wd = {hpg_q, hpin_q, 1'b0};
          end
          default: mem_we = 1'b0;
        endcase
      end
    end
  end

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> req_stall_o) else $error("accept while busy");
  a_fcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CountW'(PoolSize)) else $error("free count overflow");
  a_lcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= CountW'(PoolSize)) else $error("lru count overflow");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && rsp_stall_i |=> rsp_v_q && $stable(rsp_q)) else $error("result dropped");

endmodule
